FILE: rtl/obstacle_cost_accumulator_defines.svh
// Assertion macros shared by the obstacle cost accumulator RTL.
`ifndef OBSTACLE_COST_ACCUMULATOR_DEFINES_SVH
`define OBSTACLE_COST_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define OCA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OCA_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define OCA_ASSERT(lbl, clk, rst, prop, msg)
`define OCA_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

FILE: rtl/oca_pkg.sv
// Shared constants and types of the obstacle cost accumulator.
`timescale 1ns / 1ps
package oca_pkg;
   localparam int COORD_BITS_DEF = 15;
   localparam int RADIUS_BITS    = 12;
   localparam int SLOPE_BITS     = 16;
   localparam int SUM_BITS       = 32;
   localparam int FRAC_BITS      = 8;
   localparam int W_BITS         = 9;
   localparam int QUEUE_DEPTH    = 4;
   localparam logic [SLOPE_BITS-1:0] SLOPE_RESET = 16'd256;
   localparam logic [W_BITS-1:0]     W_ONE       = 9'd256;
   localparam logic [W_BITS-1:0]     W_ZERO      = 9'd0;
   localparam logic [3:0]            RD_DIVISOR  = 4'd10;

   typedef struct packed {
      logic valid;
      logic last;
   } item_flags_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ROOT, ST_RD, ST_SCALE, ST_MULT,
      ST_WEIGHT, ST_WDIV, ST_PROD, ST_SUM, ST_DONE
   } back_state_type;
endpackage

FILE: rtl/oca_front.sv
// Front end: takes transactions, forms squared distances, pushes them to the queue.
`timescale 1ns / 1ps
module oca_front #(
   parameter int COORD_BITS = oca_pkg::COORD_BITS_DEF,
   localparam int TDATA_W = ((4 * COORD_BITS + oca_pkg::RADIUS_BITS + 7) / 8) * 8,
   localparam int QW = 2 * COORD_BITS + 1,
   localparam int EW = 2 * QW + oca_pkg::RADIUS_BITS + 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,
   input  logic               req_tuser,
   input  logic               req_tlast,
   output logic               q_push,
   output logic [EW-1:0]      q_data,
   input  logic               q_full
);
   import oca_pkg::*;
   localparam int C = COORD_BITS;

   logic                   stg_valid_ff, stg_valid_in;
   logic signed [C:0]      dx_ff, dy_ff;
   logic signed [C-1:0]    ox_ff, oy_ff;
   logic [RADIUS_BITS-1:0] rad_ff;
   item_flags_type         flags_ff;
   logic signed [C-1:0]    px, py, ox, oy;
   logic [C-1:0]           adx, ady, aox, aoy;
   logic [QW-1:0]          qd, qo;
   logic                   take;

   assign px = $signed(req_tdata[C-1:0]);
   assign py = $signed(req_tdata[2*C-1:C]);
   assign ox = $signed(req_tdata[3*C-1:2*C]);
   assign oy = $signed(req_tdata[4*C-1:3*C]);

   assign q_push     = stg_valid_ff && !q_full;
   assign req_tready = !stg_valid_ff || !q_full;
   assign take       = req_tvalid && req_tready;
   assign stg_valid_in = take ? 1'b1 : (q_push ? 1'b0 : stg_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         dx_ff    <= {px[C-1], px} - {ox[C-1], ox};
         dy_ff    <= {py[C-1], py} - {oy[C-1], oy};
         ox_ff    <= ox;
         oy_ff    <= oy;
         rad_ff   <= req_tdata[4*C+RADIUS_BITS-1:4*C];
         flags_ff <= '{valid: req_tuser, last: req_tlast};
      end
   end

   always_comb begin
      adx = dx_ff[C] ? C'(-dx_ff) : dx_ff[C-1:0];
      ady = dy_ff[C] ? C'(-dy_ff) : dy_ff[C-1:0];
      aox = ox_ff[C-1] ? C'(-ox_ff) : C'(ox_ff);
      aoy = oy_ff[C-1] ? C'(-oy_ff) : C'(oy_ff);
      qd  = QW'(adx * adx) + QW'(ady * ady);
      qo  = QW'(aox * aox) + QW'(aoy * aoy);
   end

   assign q_data = {flags_ff, rad_ff, qo, qd};
endmodule

FILE: rtl/oca_queue.sv
// Small FIFO between front and back end.
`timescale 1ns / 1ps
`include "obstacle_cost_accumulator_defines.svh"
module oca_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = oca_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   `OCA_NEVER(a_q_overflow, clock, reset, push && full && !pop, "queue push while full")
   `OCA_NEVER(a_q_underflow, clock, reset, pop && empty, "queue pop while empty")
   `OCA_ASSERT(a_q_count, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1), "queue count did not advance")
endmodule

FILE: rtl/oca_sqrt.sv
// Bit-serial square root, takes two radicand bits of input per cycle, Q8 result.
`timescale 1ns / 1ps
module oca_sqrt #(
   parameter int COORD_BITS = oca_pkg::COORD_BITS_DEF,
   localparam int QW = 2 * COORD_BITS + 1,
   localparam int RT = COORD_BITS + 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [QW-1:0] radicand,
   output logic          busy,
   output logic [RT-1:0] root
);
   localparam int SW  = QW + 1;
   localparam int RMW = RT + 2;
   localparam int NW  = $clog2(RT);

   logic            busy_ff, busy_in;
   logic [NW-1:0]   cnt_ff, cnt_in;
   logic [SW-1:0]   sh_ff;
   logic [RT-1:0]   root_ff;
   logic [RMW-1:0]  rem_ff, rem_n, trial;

   assign busy = busy_ff;
   assign root = root_ff;

   always_comb begin
      rem_n   = {rem_ff[RMW-3:0], sh_ff[SW-1:SW-2]};
      trial   = {root_ff, 2'b01};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == NW'(RT - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sh_ff   <= {1'b0, radicand};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         sh_ff <= {sh_ff[SW-3:0], 2'b00};
         if (rem_n >= trial) begin
            rem_ff  <= rem_n - trial;
            root_ff <= {root_ff[RT-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_n;
            root_ff <= {root_ff[RT-2:0], 1'b0};
         end
      end
   end
endmodule

FILE: rtl/oca_back.sv
// Back end: distances, weight division, saturating accumulation and result register.
`timescale 1ns / 1ps
`include "obstacle_cost_accumulator_defines.svh"
module oca_back #(
   parameter int COORD_BITS = oca_pkg::COORD_BITS_DEF,
   localparam int QW = 2 * COORD_BITS + 1,
   localparam int EW = 2 * QW + oca_pkg::RADIUS_BITS + 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [oca_pkg::SLOPE_BITS-1:0]    slope_scale,
   input  logic [EW-1:0]                     q_data,
   input  logic                              q_empty,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [oca_pkg::SUM_BITS-1:0]      rsp_tdata,
   output logic                              rsp_tuser
);
   import oca_pkg::*;
   localparam int RT  = COORD_BITS + 9;
   localparam int RQ  = RADIUS_BITS + FRAC_BITS;
   localparam int RW  = ((RT > RQ) ? RT : RQ) + 1;
   localparam int SW  = RW + FRAC_BITS;
   localparam int DW  = SW + 1;
   localparam int PW  = RW + 1 + W_BITS + 1;
   localparam int CW  = PW - FRAC_BITS;
   localparam int XW  = ((CW > SUM_BITS) ? CW : SUM_BITS) + 1;
   localparam int NW  = $clog2(FRAC_BITS + 1);
   // floor(o / 10) as (o * ceil(2^k / 10)) >> k, exact for every root width
   localparam int RD_SHIFT = RT + 4;
   localparam logic [RT:0] RD_RECIP =
      (RT + 1)'(((64'd1 << RD_SHIFT) + 64'(RD_DIVISOR) - 64'd1) / 64'(RD_DIVISOR));

   back_state_type        state_ff, state_in;
   logic                  root_start, emit, div_step;
   logic                  d_busy, o_busy;
   logic [RT-1:0]         d_root, o_root;
   logic [2*RT:0]         rd_prod;
   item_flags_type        flags_ff, q_flags;
   logic [RQ-1:0]         rad_ff;
   logic [RW-1:0]         r_ff, d_ext, diff;
   logic signed [RW:0]    a_ff;
   logic [SW-1:0]         s_ff, diff_ext;
   logic [SLOPE_BITS+RW-1:0] s_prod;
   logic [DW-1:0]         drem_ff, dtry;
   logic [RT-1:0]         dnum_ff;
   logic [SW-1:0]         ddiv_ff;
   logic [NW-1:0]         dcnt_ff;
   logic [W_BITS-1:0]     w_ff;
   logic signed [PW-1:0]  prod_ff;
   logic signed [CW-1:0]  contrib;
   logic signed [XW-1:0]  total;
   logic                  ovf_hi, ovf_lo, div_done;
   logic [SUM_BITS-1:0]   sum_ff;
   logic                  clip_ff;
   logic                  rsp_valid_ff;
   logic [SUM_BITS-1:0]   rsp_data_ff;
   logic                  rsp_sat_ff;

   assign q_flags = q_data[EW-1:EW-2];

   oca_sqrt #(.COORD_BITS(COORD_BITS)) u_sqrt_d (
      .clock(clock), .reset(reset), .start(root_start),
      .radicand(q_data[QW-1:0]), .busy(d_busy), .root(d_root)
   );

   oca_sqrt #(.COORD_BITS(COORD_BITS)) u_sqrt_o (
      .clock(clock), .reset(reset), .start(root_start),
      .radicand(q_data[2*QW-1:QW]), .busy(o_busy), .root(o_root)
   );

   assign rd_prod  = o_root * RD_RECIP;
   assign d_ext    = RW'(d_root);
   assign diff     = d_ext - r_ff;
   assign diff_ext = SW'(diff);
   assign s_prod   = slope_scale * r_ff;
   assign dtry     = {drem_ff[DW-2:0], dnum_ff[RT-1]};
   assign div_done = (dcnt_ff == NW'(FRAC_BITS));
   assign contrib  = prod_ff[PW-1:FRAC_BITS];
   assign total    = $signed({{(XW - SUM_BITS){sum_ff[SUM_BITS-1]}}, sum_ff})
                   + $signed({{(XW - CW){contrib[CW-1]}}, contrib});
   assign ovf_hi   = !total[XW-1] && (|total[XW-2:SUM_BITS-1]);
   assign ovf_lo   = total[XW-1] && !(&total[XW-2:SUM_BITS-1]);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = q_flags.valid ? ST_ROOT : ST_DONE;
            end
         end
         ST_ROOT: begin
            if (!d_busy && !o_busy) begin
               state_in = ST_RD;
            end
         end
         ST_RD:     state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_MULT;
         ST_MULT:   state_in = ST_WEIGHT;
         ST_WEIGHT: begin
            if (d_ext <= r_ff || diff_ext >= s_ff) begin
               state_in = ST_PROD;
            end else begin
               state_in = ST_WDIV;
            end
         end
         ST_WDIV: begin
            if (div_done) begin
               state_in = ST_PROD;
            end
         end
         ST_PROD:   state_in = ST_SUM;
         ST_SUM:    state_in = ST_DONE;
         ST_DONE: begin
            if (!flags_ff.last || !rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop      = 1'b0;
      root_start = 1'b0;
      emit       = 1'b0;
      div_step   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            q_pop      = !q_empty;
            root_start = !q_empty && q_flags.valid;
         end
         ST_WDIV:        div_step = !div_done;
         ST_DONE:        emit = flags_ff.last && (!rsp_valid_ff || rsp_tready);
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            sum_ff  <= '0;
            clip_ff <= 1'b0;
         end else if (state_ff == ST_SUM) begin
            if (ovf_hi) begin
               sum_ff  <= {1'b0, {(SUM_BITS - 1){1'b1}}};
               clip_ff <= 1'b1;
            end else if (ovf_lo) begin
               sum_ff  <= {1'b1, {(SUM_BITS - 1){1'b0}}};
               clip_ff <= 1'b1;
            end else begin
               sum_ff <= total[SUM_BITS-1:0];
            end
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         flags_ff <= q_flags;
         rad_ff   <= {q_data[EW-3:2*QW], {FRAC_BITS{1'b0}}};
      end
      if (emit) begin
         rsp_data_ff <= sum_ff;
         rsp_sat_ff  <= clip_ff;
      end
      // origin distance by ten in one multiply, then the shift-subtract weight divide
      if (state_ff == ST_RD) begin
         dnum_ff <= RT'(rd_prod[2*RT:RD_SHIFT]);
      end else if (state_ff == ST_WEIGHT) begin
         drem_ff <= DW'(s_ff - diff_ext);
         dnum_ff <= '0;
         ddiv_ff <= s_ff;
         dcnt_ff <= '0;
      end else if (div_step) begin
         dcnt_ff <= dcnt_ff + 1'b1;
         if (dtry >= {1'b0, ddiv_ff}) begin
            drem_ff <= dtry - {1'b0, ddiv_ff};
            dnum_ff <= {dnum_ff[RT-2:0], 1'b1};
         end else begin
            drem_ff <= dtry;
            dnum_ff <= {dnum_ff[RT-2:0], 1'b0};
         end
      end
      if (state_ff == ST_SCALE) begin
         r_ff <= RW'(rad_ff) + RW'(dnum_ff);
         a_ff <= $signed((RW + 1)'(rad_ff)) - $signed((RW + 1)'(dnum_ff));
      end
      if (state_ff == ST_MULT) begin
         s_ff <= s_prod[SLOPE_BITS+RW-1:FRAC_BITS];
      end
      if (state_ff == ST_WEIGHT) begin
         w_ff <= (d_ext <= r_ff) ? W_ONE : W_ZERO;
      end else if (state_ff == ST_WDIV && div_done) begin
         w_ff <= {1'b0, dnum_ff[FRAC_BITS-1:0]};
      end
      if (state_ff == ST_PROD) begin
         prod_ff <= $signed({1'b0, w_ff}) * a_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   `OCA_ASSERT(a_clear_after_emit, clock, reset, emit |=> (sum_ff == '0 && !clip_ff), "sum not cleared after result")
   `OCA_ASSERT(a_weight_range, clock, reset, (state_ff == ST_PROD) |-> (w_ff <= W_ONE), "weight above one")
   `OCA_ASSERT(a_pop_idle, clock, reset, q_pop |-> (state_ff == ST_IDLE && !q_empty), "pop outside idle")
   `OCA_NEVER(a_emit_overwrite, clock, reset, emit && rsp_valid_ff && !rsp_tready, "result register overwritten")
endmodule

FILE: rtl/obstacle_cost_accumulator.sv
// Top level of the obstacle cost accumulator.
//
// Usage:
//   req_* channel carries one query point and one obstacle per transaction.
//   req_tuser marks a real obstacle; req_tlast closes the list for the point.
//   rsp_* channel returns the saturating Q8 cost sum once per closed list,
//   with rsp_tuser set if the sum clipped since the last result.
//   csr_wr_en / csr_wr_data write the Q8.8 slope scale (reset value 1.0).
// Flow:
//   The front stage takes a transaction per cycle into a four-entry queue
//   while the queue is not full. The back end works one obstacle at a time:
//   two bit-serial square roots run side by side, the divide by ten is one
//   reciprocal multiply, the weight divide runs only when needed, and an
//   empty item skips the arithmetic. The result is loaded into the output
//   register as the last item leaves its done state.
// Reset clears the sum, the queue and the result valid flag and sets slope to
// 1.0. A stalled receiver holds the result; the back end waits only when a
// new result is ready and the register is still full, while the queue keeps
// taking transactions until it fills.
`timescale 1ns / 1ps
module obstacle_cost_accumulator #(
   parameter int COORD_BITS = oca_pkg::COORD_BITS_DEF,
   localparam int TDATA_W = ((4 * COORD_BITS + oca_pkg::RADIUS_BITS + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // point_x, point_y, obstacle_x, obstacle_y, obstacle_radius, zero pad
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [TDATA_W-1:0]             req_tdata,
   // obstacle_valid
   input  logic                           req_tuser,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // cost_sum
   output logic [oca_pkg::SUM_BITS-1:0]   rsp_tdata,
   // saturated
   output logic                           rsp_tuser,
   input  logic                           csr_wr_en,
   input  logic [oca_pkg::SLOPE_BITS-1:0] csr_wr_data
);
   import oca_pkg::*;
   localparam int QW = 2 * COORD_BITS + 1;
   localparam int EW = 2 * QW + RADIUS_BITS + 2;

   logic [SLOPE_BITS-1:0] slope_ff;
   logic                  q_push, q_full, q_pop, q_empty;
   logic [EW-1:0]         q_in, q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff <= SLOPE_RESET;
      end else if (csr_wr_en) begin
         slope_ff <= csr_wr_data;
      end
   end

   oca_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .q_push(q_push), .q_data(q_in), .q_full(q_full)
   );

   oca_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .pop_data(q_out), .empty(q_empty)
   );

   oca_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock(clock), .reset(reset), .slope_scale(slope_ff),
      .q_data(q_out), .q_empty(q_empty), .q_pop(q_pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );
endmodule
